// File: hw/rtl/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants for the LZSS stream decoder: window geometry,
// controller states, token kinds and the command/status groups.
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int WIN_DEPTH   = 4096;
    localparam int WIN_ADDR_W  = $clog2(WIN_DEPTH);
    localparam int FILL_W      = WIN_ADDR_W + 1;
    localparam int LOOKAHEAD   = 18;
    localparam int REMAIN_W    = $clog2(LOOKAHEAD);

    localparam logic [WIN_ADDR_W-1:0] WRITE_START = WIN_ADDR_W'(WIN_DEPTH - LOOKAHEAD);
    localparam logic [FILL_W-1:0]     FILL_FULL   = FILL_W'(WIN_DEPTH);
    localparam logic [7:0]            SPACE_BYTE  = 8'h20;
    localparam logic [7:0]            FLAG_FILL   = 8'hff;
    // bytes left after the first one of a match: length code + 3 - 1
    localparam logic [REMAIN_W-1:0]   MATCH_EXTRA = REMAIN_W'(2);

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } ctrl_state_t;

    typedef enum logic [1:0] {
        TOK_FLAG,
        TOK_LIT,
        TOK_FIRST,
        TOK_SECOND
    } token_t;

    typedef struct packed {
        logic   take;
        token_t kind;
        logic   copy_step;
    } lzsd_cmd_t;

    typedef struct packed {
        logic await_second;
        logic flag_empty;
        logic flag_lit;
        logic copy_last;
        logic out_free;
    } lzsd_stat_t;

endpackage

// File: hw/rtl/lzss_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// Output: a literal appears in the cycle after it is taken; a match's bytes
// (3 to 18) follow via the copy state, one per cycle while out_stall is low.
// Input: one item per cycle for flag, literal and first match byte while
// out_stall is low; a match holds the input until its copy is done.
// Reset: state cleared at once; a fill count makes unwritten window bytes read
// as space, so neither reset nor the end of a stream needs a clearing pass.
// ----------------------------------------------------------------------------
// lzss_stream_decoder_unit
// LZSS decoder with a 4096-byte ring window: one compressed byte in per item;
// a literal yields one decompressed byte, a match 3 to 18, a flag byte none.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] compressed_byte,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last
);
    import lzsd_pkg::*;

    lzsd_cmd_t  cmd;
    lzsd_stat_t stat;

    lzsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lzsd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_byte   (compressed_byte),
        .in_last   (last_in),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

// File: hw/rtl/lzsd_ctrl.sv
// ----------------------------------------------------------------------------
// lzsd_ctrl
// Controller: classifies each incoming byte and sequences match copies,
// one window byte per cycle while the output register can take it.
// ----------------------------------------------------------------------------
module lzsd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lzsd_pkg::lzsd_stat_t stat,
    output lzsd_pkg::lzsd_cmd_t  cmd
);
    import lzsd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    token_t      kind;

    always_comb
    begin
        if (stat.await_second)
        begin
            kind = TOK_SECOND;
        end
        else if (stat.flag_empty)
        begin
            kind = TOK_FLAG;
        end
        else if (stat.flag_lit)
        begin
            kind = TOK_LIT;
        end
        else
        begin
            kind = TOK_FIRST;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.out_free && kind == TOK_SECOND)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (stat.out_free && stat.copy_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall      = 1'b1;
        cmd.take      = 1'b0;
        cmd.kind      = kind;
        cmd.copy_step = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = !stat.out_free;
                cmd.take = in_valid && stat.out_free;
            end
            ST_COPY:
            begin
                cmd.copy_step = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/lzsd_datapath.sv
// ----------------------------------------------------------------------------
// lzsd_datapath
// Datapath: 4096-byte ring window, flag shifter, match address/count,
// output register. A fill count marks which window entries were written
// since reset or the end of a stream; others read as space.
// ----------------------------------------------------------------------------
module lzsd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lzsd_pkg::lzsd_cmd_t  cmd,
    output lzsd_pkg::lzsd_stat_t stat,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 run_last
);
    import lzsd_pkg::*;

    logic [7:0]            window_mem [WIN_DEPTH];

    logic [15:0]           flag_reg,       flag_next;
    logic                  await_reg,      await_next;
    logic [7:0]            held_reg,       held_next;
    logic [WIN_ADDR_W-1:0] wpos_reg,       wpos_next;
    logic [FILL_W-1:0]     fill_reg,       fill_next;
    logic [WIN_ADDR_W-1:0] copy_addr_reg,  copy_addr_next;
    logic [REMAIN_W-1:0]   remain_reg,     remain_next;
    logic                  last_pend_reg,  last_pend_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [7:0]            out_byte_reg,   out_byte_next;
    logic                  run_last_reg,   run_last_next;

    logic [7:0]            rd_data_reg;
    logic                  bypass_reg,     bypass_next;
    logic [7:0]            bypass_data_reg;
    logic                  hit_reg,        hit_next;

    logic                  we;
    logic [7:0]            wdata;
    logic                  clear;
    logic [7:0]            copy_byte;
    logic [WIN_ADDR_W-1:0] rd_offset;

    // window byte at copy_addr_reg, with write-through and unwritten -> space
    always_comb
    begin
        if (!hit_reg)
        begin
            copy_byte = SPACE_BYTE;
        end
        else if (bypass_reg)
        begin
            copy_byte = bypass_data_reg;
        end
        else
        begin
            copy_byte = rd_data_reg;
        end
    end

    always_comb
    begin
        flag_next      = flag_reg;
        await_next     = await_reg;
        held_next      = held_reg;
        wpos_next      = wpos_reg;
        fill_next      = fill_reg;
        copy_addr_next = copy_addr_reg;
        remain_next    = remain_reg;
        last_pend_next = last_pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        we             = 1'b0;
        wdata          = in_byte;
        clear          = 1'b0;

        if (cmd.take)
        begin
            case (cmd.kind)
                TOK_FLAG:
                begin
                    flag_next = {FLAG_FILL, in_byte};
                end
                TOK_LIT:
                begin
                    we             = 1'b1;
                    wdata          = in_byte;
                    out_byte_next  = in_byte;
                    run_last_next  = 1'b1;
                    out_valid_next = 1'b1;
                    flag_next      = flag_reg >> 1;
                end
                TOK_FIRST:
                begin
                    held_next  = in_byte;
                    await_next = 1'b1;
                end
                TOK_SECOND:
                begin
                    copy_addr_next = {in_byte[7:4], held_reg};
                    remain_next    = REMAIN_W'(in_byte[3:0]) + MATCH_EXTRA;
                    last_pend_next = in_last;
                    await_next     = 1'b0;
                    flag_next      = flag_reg >> 1;
                end
                default:
                begin
                    flag_next = flag_reg;
                end
            endcase
            // a match's reset waits until its copy is done
            if (in_last && cmd.kind != TOK_SECOND)
            begin
                clear = 1'b1;
            end
        end
        else if (cmd.copy_step)
        begin
            we             = 1'b1;
            wdata          = copy_byte;
            out_byte_next  = copy_byte;
            run_last_next  = (remain_reg == '0);
            out_valid_next = 1'b1;
            copy_addr_next = copy_addr_reg + 1'b1;
            remain_next    = remain_reg - 1'b1;
            if (remain_reg == '0 && last_pend_reg)
            begin
                clear = 1'b1;
            end
        end

        if (we)
        begin
            wpos_next = wpos_reg + 1'b1;
            if (fill_reg != FILL_FULL)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end

        if (clear)
        begin
            flag_next      = '0;
            await_next     = 1'b0;
            held_next      = '0;
            wpos_next      = WRITE_START;
            fill_next      = '0;
            last_pend_next = 1'b0;
        end

        // entries are written in order from WRITE_START, so validity is a range test
        rd_offset   = copy_addr_next - WRITE_START;
        hit_next    = {1'b0, rd_offset} < fill_next;
        bypass_next = we && (wpos_reg == copy_addr_next);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            window_mem[wpos_reg] <= wdata;
        end
        rd_data_reg     <= window_mem[copy_addr_next];
        bypass_data_reg <= wdata;
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        copy_addr_reg <= copy_addr_next;
        out_byte_reg  <= out_byte_next;
        run_last_reg  <= run_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= '0;
            await_reg     <= 1'b0;
            wpos_reg      <= WRITE_START;
            fill_reg      <= '0;
            remain_reg    <= '0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            bypass_reg    <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            flag_reg      <= flag_next;
            await_reg     <= await_next;
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            remain_reg    <= remain_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
            bypass_reg    <= bypass_next;
            hit_reg       <= hit_next;
        end
    end

    assign stat.await_second = await_reg;
    assign stat.flag_empty   = !flag_reg[8];
    assign stat.flag_lit     = flag_reg[0];
    assign stat.copy_last    = (remain_reg == '0);
    assign stat.out_free     = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

// File: tb/sv/lzss_stream_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder_unit_tb
// Self-checking bench for the LZSS stream decoder. Compressed streams (hand
// built corner cases, then random well-formed streams with some noise and
// truncated streams) are pushed through the input channel. A scoreboard
// decodes every accepted item with its own ring window and compares each
// decoded byte and its run_last mark with what the block emits. Both sides
// idle at random, and the output side holds off once long enough to back up
// the input.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_unit_tb;

    import lzsd_pkg::*;

    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 29;
    // the last random stream may run past this
    localparam int STIM_ITEMS   = 240;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 90;
    localparam int QUIET_FROM   = 150;
    localparam int QUIET_TO     = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int MIN_MATCH    = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       tail;
    } decoded_t;

    class lzss_decode_scoreboard;
        logic [7:0]            history [WIN_DEPTH];
        logic [WIN_ADDR_W-1:0] put_pos;
        logic [15:0]           flag_bits;
        logic                  second_due;
        logic [7:0]            low_pos;
        decoded_t              decoded_q[$];
        int                    errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (history[i])
                history[i] = SPACE_BYTE;
            put_pos    = WRITE_START;
            flag_bits  = '0;
            second_due = 1'b0;
            low_pos    = '0;
        endfunction

        function void emit(logic [7:0] b, logic tail);
            decoded_q.push_back('{data: b, tail: tail});
            history[put_pos] = b;
            put_pos          = put_pos + 1'b1;
        endfunction

        // Decode one accepted compressed byte and queue the bytes it yields.
        function void take_input(logic [7:0] c, logic last);
            logic [WIN_ADDR_W-1:0] src;
            int                    count;
            if (second_due) begin
                src   = {c[7:4], low_pos};
                count = int'(c[3:0]) + MIN_MATCH;
                for (int k = 0; k < count; k++)
                    emit(history[src + WIN_ADDR_W'(k)], k == count - 1);
                second_due = 1'b0;
                flag_bits  = flag_bits >> 1;
            end
            else if (!flag_bits[8]) begin
                flag_bits = {FLAG_FILL, c};
            end
            else if (flag_bits[0]) begin
                emit(c, 1'b1);
                flag_bits = flag_bits >> 1;
            end
            else begin
                low_pos    = c;
                second_due = 1'b1;
            end
            if (last)
                restart();
        endfunction

        function void check_output(logic [7:0] b, logic tail);
            decoded_t want;
            if (decoded_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output byte %h run_last %b", b, tail);
            end
            else begin
                want = decoded_q.pop_front();
                if (want.data !== b || want.tail !== tail) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: expected byte %h run_last %b, got byte %h run_last %b",
                                 want.data, want.tail, b, tail);
                end
            end
        endfunction

        function int outstanding();
            return decoded_q.size();
        endfunction
    endclass

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       in_valid        = 1'b0;
    logic       in_stall;
    logic [7:0] compressed_byte = 8'h00;
    logic       last_in         = 1'b0;
    logic       out_valid;
    logic       out_stall       = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;

    lzss_decode_scoreboard sb = new();
    logic [7:0]            stim_byte[$];
    logic                  stim_last[$];
    int                    n_taken = 0;

    lzss_stream_decoder_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .compressed_byte (compressed_byte),
        .last_in         (last_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .run_last        (run_last)
    );

    always #1 clk = ~clk;

    function automatic bit quiet_phase();
        return n_taken >= QUIET_FROM && n_taken < QUIET_TO;
    endfunction

    function automatic void add_item(logic [7:0] b, logic last);
        stim_byte.push_back(b);
        stim_last.push_back(last);
    endfunction

    function automatic void add_match(logic [11:0] src, logic [3:0] code, logic last);
        add_item(src[7:0], 1'b0);
        add_item({src[11:8], code}, last);
    endfunction

    // One random stream: mostly well-formed flag groups whose matches point
    // back into recent output, sometimes noise, sometimes cut short.
    task automatic add_stream();
        logic [7:0]            seq[$];
        logic [WIN_ADDR_W-1:0] wp;
        logic [WIN_ADDR_W-1:0] src;
        logic [7:0]            flags;
        logic [3:0]            code;
        int                    cut;
        wp = WRITE_START;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 10))
                seq.push_back(8'($urandom));
        end
        else begin
            repeat ($urandom_range(1, 5)) begin
                flags = 8'($urandom);
                seq.push_back(flags);
                for (int b = 0; b < 8; b++) begin
                    if (flags[b]) begin
                        seq.push_back(8'($urandom));
                        wp = wp + 1'b1;
                    end
                    else begin
                        if ($urandom_range(9) < 7)
                            src = wp - WIN_ADDR_W'($urandom_range(1, 40));
                        else
                            src = WIN_ADDR_W'($urandom);
                        code = 4'($urandom);
                        seq.push_back(src[7:0]);
                        seq.push_back({src[11:8], code});
                        wp = wp + WIN_ADDR_W'(code) + WIN_ADDR_W'(MIN_MATCH);
                    end
                end
            end
        end
        cut = seq.size();
        if ($urandom_range(7) == 0)
            cut = $urandom_range(1, seq.size());
        for (int i = 0; i < cut; i++)
            add_item(seq[i], i == cut - 1);
    endtask

    task automatic build_stimulus();
        // flag bits LSB first: lit, match, lit, match, then four literals
        add_item(8'hf5, 1'b0);
        add_item(8'h00, 1'b0);
        add_match(12'hfee, 4'hf, 1'b0);      // overlapping copy, longest run
        add_item(8'hff, 1'b0);
        add_match(12'hfff, 4'h0, 1'b0);      // shortest run, wraps past the top
        add_item(8'h5a, 1'b0);
        add_item(8'ha5, 1'b0);
        add_item(8'h3c, 1'b0);
        add_item(8'hc3, 1'b0);
        // all-match flag, copy from untouched window, end after first match byte
        add_item(8'h00, 1'b0);
        add_match(12'h800, 4'h0, 1'b0);
        add_item(8'h12, 1'b1);
        // end on a literal
        add_item(8'h01, 1'b0);
        add_item(8'h7e, 1'b1);
        // end on a second match byte
        add_item(8'h00, 1'b0);
        add_match(12'h412, 4'h4, 1'b1);
        // end on a flag byte
        add_item(8'hfe, 1'b1);
        // window must read back as spaces after the previous stream ended
        add_item(8'h00, 1'b0);
        add_match(12'hfee, 4'hf, 1'b1);
        while (stim_byte.size() < STIM_ITEMS)
            add_stream();
    endtask

    task automatic drive_input();
        int idx;
        idx = 0;
        while (idx < stim_byte.size()) begin
            @(posedge clk);
            if (in_valid && !in_stall)
                idx++;
            // hold a stalled item as it is
            if (!(in_valid && in_stall)) begin
                if (idx < stim_byte.size() &&
                    (quiet_phase() || $urandom_range(99) >= IDLE_PCT)) begin
                    in_valid        <= 1'b1;
                    compressed_byte <= stim_byte[idx];
                    last_in         <= stim_last[idx];
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sb.take_input(compressed_byte, last_in);
                n_taken++;
            end
            if (out_valid && !out_stall)
                sb.check_output(out_byte, run_last);
        end
    end

    // Output side: random stalls, one long hold-off to back up the input.
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && n_taken >= HOLD_AT) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else begin
                out_stall <= !quiet_phase() && $urandom_range(99) < IDLE_PCT;
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        drive_input();
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lzsd_pkg.sv
hw/rtl/lzsd_ctrl.sv
hw/rtl/lzsd_datapath.sv
hw/rtl/lzss_stream_decoder_unit.sv
tb/sv/lzss_stream_decoder_unit_tb.sv
